/* rtl/core/lc3_pkg.sv */
// shared types, constants and helper functions of the lc3 instruction core
// no dependencies; used by the channel interfaces and the core

package lc3_pkg;

	// memory address width default and reset values
	localparam int ADDR_BITS_DEFAULT = 16;
	localparam logic [15:0] START_PC_RESET = 16'h3000;

	// field widths of the channels
	localparam int WORD_W = 16;
	localparam int CMD_W  = 2;
	localparam int KEY_W  = 7;
	localparam int CHAR_W = 8;
	localparam int FLAG_W = 3;

	// command codes of an input item
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_STEP    = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	// instruction opcodes
	typedef enum logic [3:0] {
		OP_BR   = 4'd0,
		OP_ADD  = 4'd1,
		OP_LD   = 4'd2,
		OP_ST   = 4'd3,
		OP_JSR  = 4'd4,
		OP_AND  = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_RTI  = 4'd8,
		OP_NOT  = 4'd9,
		OP_LDI  = 4'd10,
		OP_STI  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RSV  = 4'd13,
		OP_LEA  = 4'd14,
		OP_TRAP = 4'd15
	} opcode_t;

	// trap vectors
	localparam logic [7:0] TRAP_GETC = 8'h20;
	localparam logic [7:0] TRAP_OUT  = 8'h21;
	localparam logic [7:0] TRAP_IN   = 8'h23;
	localparam logic [7:0] TRAP_HALT = 8'h25;

	// condition codes
	localparam logic [2:0] CC_P = 3'b001;
	localparam logic [2:0] CC_Z = 3'b010;
	localparam logic [2:0] CC_N = 3'b100;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_EXEC,
		ST_INDIR,
		ST_FINISH
	} state_t;

	// sign extension of instruction offsets
	function automatic logic [15:0] sext5(input logic [4:0] v);
		return {{11{v[4]}}, v};
	endfunction

	function automatic logic [15:0] sext9(input logic [8:0] v);
		return {{7{v[8]}}, v};
	endfunction

	function automatic logic [15:0] sext11(input logic [10:0] v);
		return {{5{v[10]}}, v};
	endfunction

	// condition bits of a value written to a register
	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] cc;
		if (v == 16'd0) begin
			cc = CC_Z;
		end else if (v[15]) begin
			cc = CC_N;
		end else begin
			cc = CC_P;
		end
		return cc;
	endfunction

endpackage

/* rtl/core/lc3_chan_if.sv */
// valid/ready channel interfaces for commands into and results out of the core
// depends on lc3_pkg for field widths

interface lc3_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [lc3_pkg::CMD_W-1:0]     cmd;
	logic [lc3_pkg::WORD_W-1:0]    mem_address;
	logic [lc3_pkg::WORD_W-1:0]    mem_data;
	logic [lc3_pkg::KEY_W-1:0]     key_char;

	modport source (output valid, cmd, mem_address, mem_data, key_char, input ready);
	modport sink   (input valid, cmd, mem_address, mem_data, key_char, output ready);
endinterface

interface lc3_res_if;
	logic                          valid;
	logic                          ready;
	logic [lc3_pkg::WORD_W-1:0]    read_data;
	logic [lc3_pkg::WORD_W-1:0]    pc_now;
	logic [lc3_pkg::FLAG_W-1:0]    flags_now;
	logic                          char_valid;
	logic [lc3_pkg::CHAR_W-1:0]    char_out;
	logic                          key_taken;
	logic                          is_halted;

	modport source (output valid, read_data, pc_now, flags_now, char_valid, char_out,
		key_taken, is_halted, input ready);
	modport sink   (input valid, read_data, pc_now, flags_now, char_valid, char_out,
		key_taken, is_halted, output ready);
endinterface

/* rtl/core/lc3_instruction_core.sv */
// lc3 instruction core: sequencer, register file and single-port main memory
// depends on lc3_pkg and the channel interfaces in lc3_chan_if.sv
//
// One command is in flight at a time; a new command is taken as soon as the
// sequencer is back in idle, even while the previous result still sits in the
// output register. Load and restart go from idle straight to finish, read
// passes the read state, a step passes fetch, execute and finish, and LDI
// adds the indirect state, as the single memory port with its registered read
// serves the fetch and each dependent data access in turn. On a halted core a
// step goes straight to finish; unwritten memory words read as undefined.
// start_pc is written through cfg_wr_en/cfg_wr_data and is used on restart.

module lc3_instruction_core #(
	parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [lc3_pkg::WORD_W-1:0] cfg_wr_data,
	lc3_cmd_if.sink                    cmd_ch,
	lc3_res_if.source                  res_ch
);

	localparam int MEM_WORDS = 1 << ADDR_BITS;

	// architectural state
	lc3_pkg::state_t state_q, state_d;
	logic [15:0] pc_q, pc_d;
	logic [2:0]  flags_q, flags_d;
	logic        halt_q, halt_d;
	logic [15:0] start_pc_q;
	logic [15:0] rf_q [8];

	// per-item working registers
	logic [6:0]  key_q, key_d;
	logic [15:0] ins_q, ins_d;
	logic [15:0] rf_a_q, rf_b_q;
	logic [2:0]  rf_a_sel, rf_b_sel;
	logic [15:0] rd_data_q, rd_data_d;
	logic        char_valid_q, char_valid_d;
	logic [7:0]  char_q, char_d;
	logic        key_taken_q, key_taken_d;

	// output register
	logic        out_valid_q, out_load;
	logic [15:0] out_rd_q, out_pc_q;
	logic [2:0]  out_flags_q;
	logic        out_cv_q, out_kt_q, out_halt_q;
	logic [7:0]  out_char_q;

	// memory port
	logic [15:0]          mem [MEM_WORDS];
	logic [15:0]          mem_q;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [15:0]          mem_wdata;

	// register file write port
	logic        rf_we;
	logic [2:0]  rf_waddr;
	logic [15:0] rf_wdata;

	// decode helpers
	logic             accept;
	lc3_pkg::opcode_t op_f, op_x;
	logic [15:0]      pc_inc, offs, tgt, alu_b, cur_ins, ea_f;

	assign accept   = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == lc3_pkg::ST_IDLE);
	assign cur_ins  = mem_q;
	assign op_f     = lc3_pkg::opcode_t'(cur_ins[15:12]);
	assign op_x     = lc3_pkg::opcode_t'(ins_q[15:12]);
	assign pc_inc   = pc_q + 16'd1;
	assign ea_f     = pc_inc + lc3_pkg::sext9(cur_ins[8:0]);
	assign offs     = (op_x == lc3_pkg::OP_JSR) ? lc3_pkg::sext11(ins_q[10:0])
		: lc3_pkg::sext9(ins_q[8:0]);
	assign tgt      = pc_q + offs;
	assign alu_b    = ins_q[5] ? lc3_pkg::sext5(ins_q[4:0]) : rf_b_q;

	// register file read selects during fetch
	always_comb begin
		rf_a_sel = cur_ins[8:6];
		rf_b_sel = cur_ins[2:0];
		if (op_f == lc3_pkg::OP_TRAP) begin
			rf_a_sel = 3'd0;
		end
		if (op_f == lc3_pkg::OP_ST || op_f == lc3_pkg::OP_STI) begin
			rf_b_sel = cur_ins[11:9];
		end
	end

	// sequencer next state and datapath control
	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		flags_d      = flags_q;
		halt_d       = halt_q;
		key_d        = key_q;
		ins_d        = ins_q;
		rd_data_d    = rd_data_q;
		char_valid_d = char_valid_q;
		char_d       = char_q;
		key_taken_d  = key_taken_q;
		mem_we       = 1'b0;
		mem_addr     = pc_q[ADDR_BITS-1:0];
		mem_wdata    = rf_b_q;
		rf_we        = 1'b0;
		rf_waddr     = ins_q[11:9];
		rf_wdata     = 16'd0;
		out_load     = 1'b0;
		case (state_q)
			lc3_pkg::ST_IDLE: begin
				if (accept) begin
					key_d        = cmd_ch.key_char;
					rd_data_d    = 16'd0;
					char_valid_d = 1'b0;
					char_d       = 8'd0;
					key_taken_d  = 1'b0;
					state_d      = lc3_pkg::ST_FINISH;
					case (lc3_pkg::cmd_t'(cmd_ch.cmd))
						lc3_pkg::CMD_LOAD: begin
							mem_we    = 1'b1;
							mem_addr  = cmd_ch.mem_address[ADDR_BITS-1:0];
							mem_wdata = cmd_ch.mem_data;
						end
						lc3_pkg::CMD_READ: begin
							mem_addr = cmd_ch.mem_address[ADDR_BITS-1:0];
							state_d  = lc3_pkg::ST_READ;
						end
						lc3_pkg::CMD_RESTART: begin
							pc_d   = start_pc_q;
							halt_d = 1'b0;
						end
						lc3_pkg::CMD_STEP: begin
							if (!halt_q) begin
								state_d = lc3_pkg::ST_FETCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			lc3_pkg::ST_READ: begin
				rd_data_d = mem_q;
				state_d   = lc3_pkg::ST_FINISH;
			end
			lc3_pkg::ST_FETCH: begin
				// latch instruction, bump pc, start the data read
				ins_d    = cur_ins;
				pc_d     = pc_inc;
				mem_addr = ea_f[ADDR_BITS-1:0];
				state_d  = lc3_pkg::ST_EXEC;
			end
			lc3_pkg::ST_EXEC: begin
				state_d = lc3_pkg::ST_FINISH;
				case (op_x)
					lc3_pkg::OP_ADD, lc3_pkg::OP_AND: begin
						rf_we    = 1'b1;
						rf_wdata = (op_x == lc3_pkg::OP_ADD) ? rf_a_q + alu_b : rf_a_q & alu_b;
						flags_d  = lc3_pkg::cc_of(rf_wdata);
					end
					lc3_pkg::OP_NOT: begin
						rf_we    = 1'b1;
						rf_wdata = ~rf_a_q;
						flags_d  = lc3_pkg::cc_of(rf_wdata);
					end
					lc3_pkg::OP_LEA: begin
						rf_we    = 1'b1;
						rf_wdata = tgt;
						flags_d  = lc3_pkg::cc_of(rf_wdata);
					end
					lc3_pkg::OP_LD: begin
						rf_we    = 1'b1;
						rf_wdata = mem_q;
						flags_d  = lc3_pkg::cc_of(rf_wdata);
					end
					lc3_pkg::OP_BR: begin
						if ((ins_q[11:9] & flags_q) != 3'd0) begin
							pc_d = tgt;
						end
					end
					lc3_pkg::OP_JMP: begin
						pc_d = rf_a_q;
					end
					lc3_pkg::OP_JSR: begin
						// base register was read before r7 is overwritten
						pc_d     = ins_q[11] ? tgt : rf_a_q;
						rf_we    = 1'b1;
						rf_waddr = 3'd7;
						rf_wdata = pc_q;
					end
					lc3_pkg::OP_ST: begin
						mem_we   = 1'b1;
						mem_addr = tgt[ADDR_BITS-1:0];
					end
					lc3_pkg::OP_STI: begin
						mem_we   = 1'b1;
						mem_addr = mem_q[ADDR_BITS-1:0];
					end
					lc3_pkg::OP_LDI: begin
						mem_addr = mem_q[ADDR_BITS-1:0];
						state_d  = lc3_pkg::ST_INDIR;
					end
					lc3_pkg::OP_TRAP: begin
						case (ins_q[7:0])
							lc3_pkg::TRAP_GETC, lc3_pkg::TRAP_IN: begin
								rf_we       = 1'b1;
								rf_waddr    = 3'd0;
								rf_wdata    = {9'd0, key_q};
								key_taken_d = 1'b1;
							end
							lc3_pkg::TRAP_OUT: begin
								char_valid_d = 1'b1;
								char_d       = rf_a_q[7:0];
							end
							lc3_pkg::TRAP_HALT: begin
								halt_d = 1'b1;
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			lc3_pkg::ST_INDIR: begin
				rf_we    = 1'b1;
				rf_wdata = mem_q;
				flags_d  = lc3_pkg::cc_of(rf_wdata);
				state_d  = lc3_pkg::ST_FINISH;
			end
			lc3_pkg::ST_FINISH: begin
				// hand the result to the output register once it is free
				if (!out_valid_q || res_ch.ready) begin
					out_load = 1'b1;
					state_d  = lc3_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lc3_pkg::ST_IDLE;
			end
		endcase
	end

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lc3_pkg::ST_IDLE;
			pc_q       <= lc3_pkg::START_PC_RESET;
			flags_q    <= 3'd0;
			halt_q     <= 1'b0;
			start_pc_q <= lc3_pkg::START_PC_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			flags_q <= flags_d;
			halt_q  <= halt_d;
			if (cfg_wr_en) begin
				start_pc_q <= cfg_wr_data;
			end
			out_valid_q <= out_load || (out_valid_q && !res_ch.ready);
		end
	end

	// register file, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 16'd0;
			end
		end else if (rf_we) begin
			rf_q[rf_waddr] <= rf_wdata;
		end
	end

	// registered register file reads and working payload
	always_ff @(posedge clk) begin
		rf_a_q       <= rf_q[rf_a_sel];
		rf_b_q       <= rf_q[rf_b_sel];
		key_q        <= key_d;
		ins_q        <= ins_d;
		rd_data_q    <= rd_data_d;
		char_valid_q <= char_valid_d;
		char_q       <= char_d;
		key_taken_q  <= key_taken_d;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q    <= rd_data_q;
			out_pc_q    <= pc_q;
			out_flags_q <= flags_q;
			out_cv_q    <= char_valid_q;
			out_char_q  <= char_q;
			out_kt_q    <= key_taken_q;
			out_halt_q  <= halt_q;
		end
	end

	// main memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		mem_q <= mem[mem_addr];
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.read_data  = out_rd_q;
	assign res_ch.pc_now     = out_pc_q;
	assign res_ch.flags_now  = out_flags_q;
	assign res_ch.char_valid = out_cv_q;
	assign res_ch.char_out   = out_char_q;
	assign res_ch.key_taken  = out_kt_q;
	assign res_ch.is_halted  = out_halt_q;

endmodule
